FILE: rtl/fqd_pkg.sv
// ----------------------------------------------------------------------------
// FIFO queue with delete: shared package
// Transaction types, request codes and sequencer states used by the queue.
// ----------------------------------------------------------------------------
package fqd_pkg;

  localparam logic [1:0] KIND_ENQUEUE = 2'd0;
  localparam logic [1:0] KIND_DEQUEUE = 2'd1;
  localparam logic [1:0] KIND_DELETE  = 2'd2;
  localparam logic [1:0] KIND_ITERATE = 2'd3;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] item_handle;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] item_out;
    logic        item_valid;
    logic [4:0]  entry_count;
    logic        last;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEQUEUE,
    ST_SEARCH,
    ST_SHIFT,
    ST_ITERATE
  } state_t;

  function automatic rsp_t make_rsp(input logic status, input logic [31:0] item,
                                    input logic valid, input logic [4:0] cnt,
                                    input logic last);
    rsp_t r;
    r.status      = status;
    r.item_out    = item;
    r.item_valid  = valid;
    r.entry_count = cnt;
    r.last        = last;
    return r;
  endfunction

endpackage

FILE: rtl/fqd_ram.sv
// ----------------------------------------------------------------------------
// FIFO queue with delete: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fqd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/fqd_ctrl.sv
// ----------------------------------------------------------------------------
// FIFO queue with delete: sequencer
// Ring head pointer, entry count, the search compare and the result register.
// ----------------------------------------------------------------------------
module fqd_ctrl #(
  parameter int DEPTH       = 16,
  parameter int HANDLE_BITS = 32
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         start,
  input  fqd_pkg::req_t                                req,
  output logic                                         busy,
  output logic                                         done,
  output fqd_pkg::rsp_t                                rsp,
  output logic                                         we,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  output logic [((HANDLE_BITS < 32) ? HANDLE_BITS : 32)-1:0] wdata,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  input  logic [((HANDLE_BITS < 32) ? HANDLE_BITS : 32)-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
  localparam logic [CW:0]   DEPTH_W = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW + 1)'(base) + {1'b0, off};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  fqd_pkg::state_t state, state_next;
  logic [AW-1:0]   head, head_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   idx, idx_next;
  logic            rd_vld, rd_vld_next;
  logic [CW-1:0]   rd_off, rd_off_next;
  logic [SW-1:0]   key, key_next;
  fqd_pkg::rsp_t   rsp_next;
  logic            done_next;

  logic            accept;
  logic [SW-1:0]   req_key;
  logic            req_null;
  logic            full;
  logic            empty;
  logic            issue_ok;
  logic            hit;
  logic            at_end;
  logic [CW-1:0]   count_inc;
  logic [CW-1:0]   count_dec;

  assign busy      = (state != fqd_pkg::ST_IDLE);
  assign accept    = start && (state == fqd_pkg::ST_IDLE);
  assign req_key   = req.item_handle[SW-1:0];
  assign req_null  = (req_key == '0);
  assign full      = (count == DEPTH_C);
  assign empty     = (count == '0);
  assign issue_ok  = (idx < count);
  assign hit       = rd_vld && (rd_data == key);
  assign count_inc = count + ONE_C;
  assign count_dec = count - ONE_C;
  assign at_end    = (rd_off == count_dec);

  always_comb begin
    state_next = state;
    unique case (state)
      fqd_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (req.kind)
            fqd_pkg::KIND_DEQUEUE: begin
              if (!empty) state_next = fqd_pkg::ST_DEQUEUE;
            end
            fqd_pkg::KIND_DELETE: begin
              if (!req_null && !empty) state_next = fqd_pkg::ST_SEARCH;
            end
            fqd_pkg::KIND_ITERATE: begin
              if (!empty) state_next = fqd_pkg::ST_ITERATE;
            end
            default: state_next = fqd_pkg::ST_IDLE;
          endcase
        end
      end
      fqd_pkg::ST_DEQUEUE: begin
        state_next = fqd_pkg::ST_IDLE;
      end
      fqd_pkg::ST_SEARCH: begin
        if (hit) begin
          state_next = at_end ? fqd_pkg::ST_IDLE : fqd_pkg::ST_SHIFT;
        end else if (rd_vld && at_end) begin
          state_next = fqd_pkg::ST_IDLE;
        end
      end
      fqd_pkg::ST_SHIFT, fqd_pkg::ST_ITERATE: begin
        if (rd_vld && at_end) state_next = fqd_pkg::ST_IDLE;
      end
      default: state_next = fqd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    head_next   = head;
    count_next  = count;
    idx_next    = idx;
    rd_vld_next = 1'b0;
    rd_off_next = idx;
    key_next    = key;
    rsp_next    = rsp;
    done_next   = 1'b0;
    we          = 1'b0;
    waddr       = wrap(head, count);
    wdata       = req_key;
    raddr       = wrap(head, idx);
    unique case (state)
      fqd_pkg::ST_IDLE: begin
        raddr    = head;
        idx_next = '0;
        if (accept) begin
          key_next = req_key;
          unique case (req.kind)
            fqd_pkg::KIND_ENQUEUE: begin
              done_next = 1'b1;
              if (req_null || full) begin
                rsp_next = fqd_pkg::make_rsp(fqd_pkg::STATUS_ERR, '0, 1'b0,
                                             5'(count), 1'b1);
              end else begin
                we         = 1'b1;
                count_next = count_inc;
                rsp_next   = fqd_pkg::make_rsp(fqd_pkg::STATUS_OK, '0, 1'b0,
                                               5'(count_inc), 1'b1);
              end
            end
            fqd_pkg::KIND_DEQUEUE: begin
              if (empty) begin
                done_next = 1'b1;
                rsp_next  = fqd_pkg::make_rsp(fqd_pkg::STATUS_ERR, '0, 1'b0,
                                              5'(count), 1'b1);
              end
            end
            fqd_pkg::KIND_DELETE: begin
              if (req_null || empty) begin
                done_next = 1'b1;
                rsp_next  = fqd_pkg::make_rsp(fqd_pkg::STATUS_ERR, '0, 1'b0,
                                              5'(count), 1'b1);
              end
            end
            default: begin
              if (empty) begin
                done_next = 1'b1;
                rsp_next  = fqd_pkg::make_rsp(fqd_pkg::STATUS_OK, '0, 1'b0,
                                              5'(count), 1'b1);
              end
            end
          endcase
        end
      end
      fqd_pkg::ST_DEQUEUE: begin
        done_next  = 1'b1;
        head_next  = wrap(head, ONE_C);
        count_next = count_dec;
        rsp_next   = fqd_pkg::make_rsp(fqd_pkg::STATUS_OK, 32'(rd_data), 1'b1,
                                       5'(count_dec), 1'b1);
      end
      fqd_pkg::ST_SEARCH: begin
        rd_vld_next = issue_ok && !hit;
        if (issue_ok && !hit) idx_next = idx + ONE_C;
        if (hit) begin
          idx_next = rd_off + ONE_C;
          if (at_end) begin
            done_next  = 1'b1;
            count_next = count_dec;
            rsp_next   = fqd_pkg::make_rsp(fqd_pkg::STATUS_OK, '0, 1'b0,
                                           5'(count_dec), 1'b1);
          end
        end else if (rd_vld && at_end) begin
          done_next = 1'b1;
          rsp_next  = fqd_pkg::make_rsp(fqd_pkg::STATUS_ERR, '0, 1'b0,
                                        5'(count), 1'b1);
        end
      end
      fqd_pkg::ST_SHIFT: begin
        rd_vld_next = issue_ok;
        if (issue_ok) idx_next = idx + ONE_C;
        if (rd_vld) begin
          we    = 1'b1;
          waddr = wrap(head, rd_off - ONE_C);
          wdata = rd_data;
          if (at_end) begin
            done_next  = 1'b1;
            count_next = count_dec;
            rsp_next   = fqd_pkg::make_rsp(fqd_pkg::STATUS_OK, '0, 1'b0,
                                           5'(count_dec), 1'b1);
          end
        end
      end
      fqd_pkg::ST_ITERATE: begin
        rd_vld_next = issue_ok;
        if (issue_ok) idx_next = idx + ONE_C;
        if (rd_vld) begin
          done_next = 1'b1;
          rsp_next  = fqd_pkg::make_rsp(fqd_pkg::STATUS_OK, 32'(rd_data), 1'b1,
                                        5'(count), at_end);
        end
      end
      default: begin
        idx_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= fqd_pkg::ST_IDLE;
      head   <= '0;
      count  <= '0;
      idx    <= '0;
      rd_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      count  <= count_next;
      idx    <= idx_next;
      rd_vld <= rd_vld_next;
      done   <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_off <= rd_off_next;
    key    <= key_next;
    rsp    <= rsp_next;
  end

endmodule

FILE: rtl/fifo_queue_with_delete_unit.sv
// ----------------------------------------------------------------------------
// FIFO queue with delete: top level
// A bounded queue of nonzero handles with enqueue, dequeue, delete by value
// and a full walk from head to tail.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high while busy is low. Every result
// appears on rsp for exactly one cycle with done high and cannot be held off.
// Enqueue, iterate on an empty queue and any request that fails at once give
// their result in the cycle after acceptance with busy staying low. Dequeue
// reads the head entry on acceptance and registers its result in ST_DEQUEUE.
// Iterate delivers one entry per cycle from head to tail. Delete gives its
// result once a search has read one entry per cycle and the entries behind a
// match have then been moved down one per cycle. Busy falls in the cycle that
// carries the final result, so the next transaction can be taken at the edge
// that accepts that result. These entry-by-entry steps come from the single
// read port of the handle storage.
// ----------------------------------------------------------------------------
module fifo_queue_with_delete_unit #(
  parameter int DEPTH       = 16,
  parameter int HANDLE_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  fqd_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output fqd_pkg::rsp_t rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;

  logic          we;
  logic [AW-1:0] waddr;
  logic [SW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [SW-1:0] rd_data;

  fqd_ctrl #(
    .DEPTH      (DEPTH),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .done   (done),
    .rsp    (rsp),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr  (raddr),
    .rd_data(rd_data)
  );

  fqd_ram #(
    .WIDTH(SW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd_data)
  );

endmodule
